### rtl/core/bwcf_pkg.sv
package bwcf_pkg;

  // Pipeline depths of the two cell rows.
  localparam int unsigned ROOT_STEPS   = 33;
  localparam int unsigned CORDIC_STEPS = 31;
  localparam int unsigned DIV_STEPS    = 64;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COORD_A = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COORD_B = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COORD_C = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COORD_D = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COORD_E = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COORD_F = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WEDGE_U = 8'd7;

  // Pi with 30 fraction bits.
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

  // atan(2^-i) with 30 fraction bits, rounded to nearest.
  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043836, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1
  };

  // Item traveling through the square root and CORDIC row.
  typedef struct packed {
    logic              valid;
    logic              disc;
    logic              box_hit;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [65:0]       rad;
    logic [35:0]       rem;
    logic [32:0]       root;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [33:0] cz;
  } root_t;

  // Item traveling through the divider row.
  typedef struct packed {
    logic        valid;
    logic        disc;
    logic        box_hit;
    logic        hit;
    logic        negx;
    logic        negy;
    logic [32:0] mag;
    logic [63:0] px;
    logic [63:0] py;
    logic [33:0] remx;
    logic [33:0] remy;
    logic [32:0] qx;
    logic [32:0] qy;
    logic        ovx;
    logic        ovy;
  } div_t;

endpackage

### rtl/core/bwcf_root_cell.sv
module bwcf_root_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bwcf_pkg::root_t   in_i,
  output bwcf_pkg::root_t   out_o
);

  localparam int unsigned K = bwcf_pkg::ROOT_STEPS - 1 - STEP;

  bwcf_pkg::root_t data_d, data_q;
  logic            valid_q;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        take;

  // One digit of the restoring square root.
  assign rem_sh = {in_i.rem[33:0], in_i.rad[2*K +: 2]};
  assign trial  = {1'b0, in_i.root, 2'b01};
  assign take   = (rem_sh >= trial);

  always_comb begin
    data_d      = in_i;
    data_d.rem  = take ? (rem_sh - trial) : rem_sh;
    data_d.root = {in_i.root[31:0], take};
    if (STEP < bwcf_pkg::CORDIC_STEPS) begin
      // One CORDIC vectoring rotation, driving y toward zero.
      if (in_i.cy > 0) begin
        data_d.cx = in_i.cx + (in_i.cy >>> STEP);
        data_d.cy = in_i.cy - (in_i.cx >>> STEP);
        data_d.cz = in_i.cz +
          $signed({2'b00, bwcf_pkg::ATAN_Q30[STEP % bwcf_pkg::CORDIC_STEPS]});
      end else begin
        data_d.cx = in_i.cx - (in_i.cy >>> STEP);
        data_d.cy = in_i.cy + (in_i.cx >>> STEP);
        data_d.cz = in_i.cz -
          $signed({2'b00, bwcf_pkg::ATAN_Q30[STEP % bwcf_pkg::CORDIC_STEPS]});
      end
    end
  end

  // Valid flag of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_i.valid;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    out_o       = data_q;
    out_o.valid = valid_q;
  end

endmodule

### rtl/core/bwcf_div_cell.sv
module bwcf_div_cell #(
  parameter int unsigned BIT = 63
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bwcf_pkg::div_t  in_i,
  output bwcf_pkg::div_t  out_o
);

  bwcf_pkg::div_t data_d, data_q;
  logic           valid_q;

  logic [33:0] shx, shy;
  logic [33:0] dvs;
  logic        gex, gey;

  // One quotient bit for each component of the force.
  assign dvs = {1'b0, in_i.mag};
  assign shx = {in_i.remx[32:0], in_i.px[BIT]};
  assign shy = {in_i.remy[32:0], in_i.py[BIT]};
  assign gex = (shx >= dvs);
  assign gey = (shy >= dvs);

  always_comb begin
    data_d      = in_i;
    data_d.remx = gex ? (shx - dvs) : shx;
    data_d.remy = gey ? (shy - dvs) : shy;
    data_d.qx   = {in_i.qx[31:0], gex};
    data_d.qy   = {in_i.qy[31:0], gey};
    // Bits shifted out above the kept quotient only mean saturation.
    data_d.ovx  = in_i.ovx | in_i.qx[32];
    data_d.ovy  = in_i.ovy | in_i.qy[32];
  end

  // Valid flag of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_i.valid;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    out_o       = data_q;
    out_o.valid = valid_q;
  end

endmodule

### rtl/core/box_or_annulus_wedge_collision_force.sv
// Contact force of one configured obstacle (a box or a disc annulus with an
// excluded wedge) on a stream of points, in signed fixed point.
// Configuration: write register cfg_index_i with cfg_data_i while cfg_valid_i
// is high; cfg_ready_o is always high. Indexes above seven are ignored.
// The user must write registers only while no item is in flight; the block does not enforce it.
// Input: a point is taken at each clock edge where start is high and busy is
// low. busy stays low, so a new item may enter in every cycle.
// Output: each item gives exactly one result, shown on force_x_o, force_y_o
// and hit_o for one cycle while strobe_o is high. Results leave in order.
// From the accepting edge to the strobe, an item passes three front stages,
// 33 square root cells (which also carry the 31 CORDIC rotations), one
// compare and multiply stage, 64 divider cells and the output register.
// Throughput is one item per cycle.
// The receiver cannot stall; results are never held back.
// Reset clears all configuration registers to zero (box mode, empty box)
// and empties the pipeline.
module box_or_annulus_wedge_collision_force #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [31:0]                 pos_x_i,
  input  logic signed [31:0]                 pos_y_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bwcf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  output logic                               strobe_o,
  output logic signed [31:0]                 force_x_o,
  output logic signed [31:0]                 force_y_o,
  output logic                               hit_o
);

  localparam int unsigned ANG_S   = 30 - FRAC_BITS;
  localparam int unsigned LATENCY = 3 + bwcf_pkg::ROOT_STEPS + 1 +
                                    bwcf_pkg::DIV_STEPS + 1;

  // Configuration registers.
  logic              shape_q;
  logic signed [31:0] ca_q, cb_q, cc_q, cd_q, ce_q, cf_q, cw_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= 1'b0;
      ca_q    <= '0;
      cb_q    <= '0;
      cc_q    <= '0;
      cd_q    <= '0;
      ce_q    <= '0;
      cf_q    <= '0;
      cw_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bwcf_pkg::REG_SHAPE:   shape_q <= cfg_data_i[0];
        bwcf_pkg::REG_COORD_A: ca_q    <= cfg_data_i;
        bwcf_pkg::REG_COORD_B: cb_q    <= cfg_data_i;
        bwcf_pkg::REG_COORD_C: cc_q    <= cfg_data_i;
        bwcf_pkg::REG_COORD_D: cd_q    <= cfg_data_i;
        bwcf_pkg::REG_COORD_E: ce_q    <= cfg_data_i;
        bwcf_pkg::REG_COORD_F: cf_q    <= cfg_data_i;
        bwcf_pkg::REG_WEDGE_U: cw_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: offsets from the centre and the box test.
  logic              s1_valid_q;
  logic              s1_disc_q, s1_box_q;
  logic signed [32:0] s1_dx_q, s1_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_disc_q <= shape_q;
    s1_box_q  <= (pos_x_i > ca_q) && (pos_x_i < cc_q) &&
                 (pos_y_i > cb_q) && (pos_y_i < cd_q);
    s1_dx_q   <= 33'(pos_x_i) - 33'(ca_q);
    s1_dy_q   <= 33'(pos_y_i) - 33'(cb_q);
  end

  // Stage 2: squares of the offset magnitudes.
  logic              s2_valid_q;
  logic              s2_disc_q, s2_box_q;
  logic signed [32:0] s2_dx_q, s2_dy_q;
  logic [63:0]       s2_sx_q, s2_sy_q;
  logic [31:0]       ux, uy;

  assign ux = s1_dx_q[32] ? 32'(-s1_dx_q) : s1_dx_q[31:0];
  assign uy = s1_dy_q[32] ? 32'(-s1_dy_q) : s1_dy_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_disc_q <= s1_disc_q;
    s2_box_q  <= s1_box_q;
    s2_dx_q   <= s1_dx_q;
    s2_dy_q   <= s1_dy_q;
    s2_sx_q   <= 64'(ux) * 64'(ux);
    s2_sy_q   <= 64'(uy) * 64'(uy);
  end

  // Stage 3: radicand and CORDIC pre-rotation into the right half plane.
  bwcf_pkg::root_t root_c [bwcf_pkg::ROOT_STEPS+1];
  bwcf_pkg::root_t s3_d, s3_q;
  logic            s3_valid_q;

  always_comb begin
    s3_d         = '0;
    s3_d.disc    = s2_disc_q;
    s3_d.box_hit = s2_box_q;
    s3_d.dx      = s2_dx_q;
    s3_d.dy      = s2_dy_q;
    s3_d.rad     = 66'(s2_sx_q) + 66'(s2_sy_q);
    if (s2_dx_q < 0) begin
      s3_d.cx = -36'(s2_dx_q);
      s3_d.cy = -36'(s2_dy_q);
      s3_d.cz = (s2_dy_q >= 0) ? bwcf_pkg::PI_Q30 : -bwcf_pkg::PI_Q30;
    end else begin
      s3_d.cx = 36'(s2_dx_q);
      s3_d.cy = 36'(s2_dy_q);
      s3_d.cz = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
  end

  always_comb begin
    root_c[0]       = s3_q;
    root_c[0].valid = s3_valid_q;
  end

  // Row of square root and CORDIC cells.
  for (genvar g = 0; g < bwcf_pkg::ROOT_STEPS; g++) begin : g_root
    bwcf_root_cell #(.STEP(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .in_i   (root_c[g]),
      .out_o  (root_c[g+1])
    );
  end

  // Stage 4: annulus and wedge tests, products for the force scaling.
  bwcf_pkg::root_t    rt;
  bwcf_pkg::div_t     div_c [bwcf_pkg::DIV_STEPS+1];
  bwcf_pkg::div_t     s4_d, s4_q;
  logic               s4_valid_q;
  logic signed [33:0] ang_rnd, ang;
  logic signed [34:0] mag_s;
  logic [31:0]        udx, udy, uf;
  logic               in_ring, in_wedge;

  assign rt      = root_c[bwcf_pkg::ROOT_STEPS];
  assign ang_rnd = rt.cz + (34'sd1 <<< (ANG_S - 1));
  assign ang     = ang_rnd >>> ANG_S;
  assign mag_s   = $signed({2'b00, rt.root});
  assign in_ring = (rt.root != '0) && (mag_s > 35'(cc_q)) && (mag_s < 35'(cd_q));
  assign in_wedge = (34'(cw_q) > ang) && (ang > 34'(cf_q));
  assign udx     = rt.dx[32] ? 32'(-rt.dx) : rt.dx[31:0];
  assign udy     = rt.dy[32] ? 32'(-rt.dy) : rt.dy[31:0];
  assign uf      = ce_q[31] ? 32'(-33'(ce_q)) : ce_q;

  always_comb begin
    s4_d         = '0;
    s4_d.disc    = rt.disc;
    s4_d.box_hit = rt.box_hit;
    s4_d.hit     = in_ring && !in_wedge;
    s4_d.negx    = rt.dx[32] != ce_q[31];
    s4_d.negy    = rt.dy[32] != ce_q[31];
    s4_d.mag     = rt.root;
    s4_d.px      = 64'(udx) * 64'(uf);
    s4_d.py      = 64'(udy) * 64'(uf);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= rt.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_q <= s4_d;
  end

  always_comb begin
    div_c[0]       = s4_q;
    div_c[0].valid = s4_valid_q;
  end

  // Row of divider cells, most significant dividend bit first.
  for (genvar g = 0; g < bwcf_pkg::DIV_STEPS; g++) begin : g_div
    bwcf_div_cell #(.BIT(bwcf_pkg::DIV_STEPS - 1 - g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .in_i   (div_c[g]),
      .out_o  (div_c[g+1])
    );
  end

  // Output stage: saturation and shape select.
  bwcf_pkg::div_t     dv;
  logic signed [31:0] satx, saty, fx_d, fy_d;
  logic               hit_d;
  logic               strobe_q, hit_q;
  logic signed [31:0] fx_q, fy_q;

  assign dv = div_c[bwcf_pkg::DIV_STEPS];

  always_comb begin
    if (dv.negx) begin
      satx = (dv.ovx || dv.qx > 33'h080000000) ? 32'sh80000000 : -$signed(dv.qx[31:0]);
    end else begin
      satx = (dv.ovx || dv.qx[32] || dv.qx[31]) ? 32'sh7FFFFFFF : $signed(dv.qx[31:0]);
    end
    if (dv.negy) begin
      saty = (dv.ovy || dv.qy > 33'h080000000) ? 32'sh80000000 : -$signed(dv.qy[31:0]);
    end else begin
      saty = (dv.ovy || dv.qy[32] || dv.qy[31]) ? 32'sh7FFFFFFF : $signed(dv.qy[31:0]);
    end
    hit_d = dv.disc ? dv.hit : dv.box_hit;
    if (!hit_d) begin
      fx_d = '0;
      fy_d = '0;
    end else if (dv.disc) begin
      fx_d = satx;
      fy_d = saty;
    end else begin
      fx_d = ce_q;
      fy_d = cf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= dv.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_q  <= fx_d;
    fy_q  <= fy_d;
    hit_q <= hit_d;
  end

  assign strobe_o  = strobe_q;
  assign force_x_o = fx_q;
  assign force_y_o = fy_q;
  assign hit_o     = hit_q;

  // Every result comes from an item accepted earlier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start && !busy, LATENCY))
    else $error("result without a matching accepted item");

  // A miss carries no force.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !hit_o |-> force_x_o == 32'sd0 && force_y_o == 32'sd0)
    else $error("force on a missed point");

  // A box hit gives the configured vector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && hit_o && !shape_q |-> force_x_o == ce_q && force_y_o == cf_q)
    else $error("box force differs from its registers");

endmodule
